[rtl/core/llde_pkg.sv]
// Package with shared types and constants of the link loss and delay emulator.
`timescale 1ns / 1ps
package llde_pkg;

    localparam int unsigned LOSS_MODULUS = 100;
    localparam logic [31:0] LFSR_MASK    = 32'hD000_0001;

    // Reciprocal of the loss modulus: x / 100 == (x * LOSS_RECIP) >> LOSS_SHIFT for 32-bit x.
    localparam logic [31:0] LOSS_RECIP   = 32'h51EB_851F;
    localparam int          LOSS_SHIFT   = 37;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_LOSS   = 2'd0;
    localparam logic [1:0] REG_BASE   = 2'd1;
    localparam logic [1:0] REG_JITTER = 2'd2;
    localparam logic [1:0] REG_SEED   = 2'd3;

    // Item modes.
    localparam logic [1:0] MODE_SEND  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  dest;
        logic [63:0] payload;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_dest;
        logic [63:0] out_payload;
        logic        last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOSS_DRAW,
        ST_LOSS_MOD,
        ST_JIT_DRAW,
        ST_JIT_MOD,
        ST_PLACE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic draw;
        logic mod_start;
        logic mod_by_jitter;
        logic loss_check;
        logic add_jitter;
        logic place;
        logic tick;
        logic scan_start;
        logic scan_step;
        logic emit_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] mode;
        logic       loss_nz;
        logic       jitter_nz;
        logic       mod_done;
        logic       loss_drop;
        logic       delay_zero;
        logic       scan_done;
        logic       hit;
        logic       out_busy;
    } ctrl_stat_t;

endpackage

[rtl/core/link_loss_delay_emulator.sv]
// Top level of the link loss and delay emulator.
`timescale 1ns / 1ps
// An item is taken only while the block is idle. A send keeps the block busy after its
// transfer: the loss draw is reduced modulo 100 by a reciprocal multiply (a send lost
// there returns to idle), and the jitter draw runs through a restoring modulo unit.
// A tick or clear walks the slots one per cycle; a tick's scan halts for each released
// message, which passes an emit and a wait state. A result that finds the output
// register still occupied waits for it. An unused mode returns straight to idle. The
// single output register lets the next item enter while the last result still waits.
module link_loss_delay_emulator #(
    parameter int QUEUE_SLOTS  = 16,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  llde_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output llde_pkg::out_item_t  m_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_wdata
);

    llde_pkg::ctrl_cmd_t  cmd;
    llde_pkg::ctrl_stat_t stat;

    llde_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    llde_datapath #(
        .QUEUE_SLOTS  (QUEUE_SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[rtl/core/llde_ctrl.sv]
// Controller state machine of the link loss and delay emulator.
`timescale 1ns / 1ps
module llde_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  llde_pkg::ctrl_stat_t  stat,
    output llde_pkg::ctrl_cmd_t   cmd
);

    llde_pkg::state_t state_reg;
    llde_pkg::state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= llde_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            llde_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = llde_pkg::ST_LOSS_DRAW;
                end
            end
            llde_pkg::ST_LOSS_DRAW: begin
                unique case (stat.mode)
                    llde_pkg::MODE_SEND: begin
                        if (stat.loss_nz) begin
                            cmd.draw      = 1'b1;
                            cmd.mod_start = 1'b1;
                            state_next    = llde_pkg::ST_LOSS_MOD;
                        end else begin
                            state_next = llde_pkg::ST_JIT_DRAW;
                        end
                    end
                    llde_pkg::MODE_TICK: begin
                        cmd.tick       = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_next     = llde_pkg::ST_SCAN;
                    end
                    llde_pkg::MODE_CLEAR: begin
                        cmd.scan_start = 1'b1;
                        state_next     = llde_pkg::ST_SCAN;
                    end
                    default: state_next = llde_pkg::ST_IDLE;
                endcase
            end
            llde_pkg::ST_LOSS_MOD: begin
                if (stat.mod_done) begin
                    cmd.loss_check = 1'b1;
                    state_next     = stat.loss_drop ? llde_pkg::ST_IDLE
                                                    : llde_pkg::ST_JIT_DRAW;
                end
            end
            llde_pkg::ST_JIT_DRAW: begin
                if (stat.jitter_nz) begin
                    cmd.draw          = 1'b1;
                    cmd.mod_start     = 1'b1;
                    cmd.mod_by_jitter = 1'b1;
                    state_next        = llde_pkg::ST_JIT_MOD;
                end else begin
                    state_next = llde_pkg::ST_PLACE;
                end
            end
            llde_pkg::ST_JIT_MOD: begin
                cmd.mod_by_jitter = 1'b1;
                if (stat.mod_done) begin
                    cmd.add_jitter = 1'b1;
                    state_next     = llde_pkg::ST_PLACE;
                end
            end
            llde_pkg::ST_PLACE: begin
                if (stat.delay_zero) begin
                    if (!stat.out_busy) begin
                        cmd.emit_load = 1'b1;
                        state_next    = llde_pkg::ST_IDLE;
                    end
                end else begin
                    cmd.place  = 1'b1;
                    state_next = llde_pkg::ST_IDLE;
                end
            end
            llde_pkg::ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = llde_pkg::ST_IDLE;
                end else if (stat.hit && stat.mode == llde_pkg::MODE_TICK) begin
                    state_next = llde_pkg::ST_EMIT;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            llde_pkg::ST_EMIT: begin
                if (!stat.out_busy) begin
                    cmd.emit_load = 1'b1;
                    cmd.scan_step = 1'b1;
                    state_next    = llde_pkg::ST_SCAN_WAIT;
                end
            end
            llde_pkg::ST_SCAN_WAIT: begin
                state_next = llde_pkg::ST_SCAN;
            end
            default: state_next = llde_pkg::ST_IDLE;
        endcase
    end

endmodule

[rtl/core/llde_datapath.sv]
// Datapath of the link loss and delay emulator: registers, LFSR, modulo unit and slot store.
`timescale 1ns / 1ps
module llde_datapath #(
    parameter int QUEUE_SLOTS  = 16,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  llde_pkg::in_item_t    s_data,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_wdata,
    input  llde_pkg::ctrl_cmd_t   cmd,
    output llde_pkg::ctrl_stat_t  stat,
    output logic                  m_valid,
    input  logic                  m_ready,
    output llde_pkg::out_item_t   m_data
);

    localparam int IW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int CW = $clog2(QUEUE_SLOTS + 1);

    // Configuration registers.
    logic [6:0]  loss_reg;
    logic [15:0] base_reg;
    logic [15:0] jitter_reg;
    logic [31:0] lfsr_reg;
    logic [31:0] lfsr_next;
    logic [31:0] now_reg;

    // Item registers.
    logic [1:0]              mode_reg;
    logic [7:0]              dest_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [31:0]             delay_reg;

    // Slot store.
    logic [QUEUE_SLOTS-1:0]  valid_reg;
    logic [7:0]              sdest_mem [QUEUE_SLOTS];
    logic [31:0]             sdue_mem  [QUEUE_SLOTS];
    logic [PAYLOAD_BITS-1:0] spay_mem  [QUEUE_SLOTS];

    // Modulo unit: restoring division by the jitter bound, one quotient bit per cycle;
    // the loss modulus goes through a reciprocal multiply instead.
    logic [31:0] rem_reg;
    logic [31:0] dvd_reg;
    logic [15:0] div_reg;
    logic [5:0]  mcnt_reg;
    logic        mbusy_reg;
    logic        mjit_reg;
    logic [26:0] quo_reg;
    logic [32:0] rem_shift;
    logic [32:0] rem_sub;
    logic [63:0] recip_prod;
    logic [31:0] loss_prod;

    // Scan pointer.
    logic [CW-1:0] scan_reg;
    logic [IW-1:0] sidx;
    logic          hit;

    // First free slot.
    logic          free_found;
    logic [IW-1:0] free_idx;

    assign lfsr_next = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ llde_pkg::LFSR_MASK)
                                   : (lfsr_reg >> 1);

    // Configuration, LFSR and tick counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loss_reg   <= '0;
            base_reg   <= '0;
            jitter_reg <= '0;
            lfsr_reg   <= 32'd1;
            now_reg    <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    llde_pkg::REG_LOSS:   loss_reg   <= cfg_wdata[6:0];
                    llde_pkg::REG_BASE:   base_reg   <= cfg_wdata[15:0];
                    llde_pkg::REG_JITTER: jitter_reg <= cfg_wdata[15:0];
                    llde_pkg::REG_SEED:
                        lfsr_reg <= (cfg_wdata != '0) ? cfg_wdata : 32'd1;
                    default: ;
                endcase
            end else if (cmd.draw) begin
                lfsr_reg <= lfsr_next;
            end
            if (cmd.tick) begin
                now_reg <= now_reg + 32'd1;
            end
        end
    end

    // Item capture and delay accumulation.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= s_data.mode;
            dest_reg  <= s_data.dest;
            pay_reg   <= s_data.payload[PAYLOAD_BITS-1:0];
            delay_reg <= {16'd0, base_reg};
        end else if (cmd.add_jitter) begin
            delay_reg <= delay_reg + {16'd0, rem_reg[15:0]};
        end
    end

    assign rem_shift  = {rem_reg, dvd_reg[31]};
    assign rem_sub    = rem_shift - {17'd0, div_reg};
    assign recip_prod = dvd_reg * llde_pkg::LOSS_RECIP;
    assign loss_prod  = {5'd0, quo_reg} * 32'(llde_pkg::LOSS_MODULUS);

    // Modulo sequencer: 32 steps for the jitter bound, two for the loss modulus.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbusy_reg <= 1'b0;
            mcnt_reg  <= '0;
        end else if (cmd.mod_start) begin
            mbusy_reg <= 1'b1;
            mcnt_reg  <= cmd.mod_by_jitter ? 6'd0 : 6'd30;
        end else if (mbusy_reg) begin
            mcnt_reg <= mcnt_reg + 6'd1;
            if (mcnt_reg == 6'd31) begin
                mbusy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mod_start) begin
            rem_reg  <= '0;
            dvd_reg  <= lfsr_next;
            div_reg  <= jitter_reg;
            mjit_reg <= cmd.mod_by_jitter;
        end else if (mbusy_reg) begin
            if (mjit_reg) begin
                dvd_reg <= {dvd_reg[30:0], 1'b0};
                rem_reg <= rem_sub[32] ? rem_shift[31:0] : rem_sub[31:0];
            end else if (mcnt_reg == 6'd30) begin
                quo_reg <= recip_prod[63:llde_pkg::LOSS_SHIFT];
            end else begin
                rem_reg <= dvd_reg - loss_prod;
            end
        end
    end

    // Lowest free slot.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = QUEUE_SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    assign sidx = scan_reg[IW-1:0];

    // Hit test for the slot under the scan pointer.
    always_comb begin
        logic [31:0] diff;
        diff = now_reg - sdue_mem[sidx];
        hit  = 1'b0;
        if (scan_reg < CW'(QUEUE_SLOTS) && valid_reg[sidx]) begin
            if (mode_reg == llde_pkg::MODE_TICK) begin
                hit = !diff[31];
            end else begin
                hit = (sdest_mem[sidx] == dest_reg);
            end
        end
    end

    // Scan pointer and valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            scan_reg  <= '0;
        end else begin
            if (cmd.scan_start) begin
                scan_reg <= '0;
            end else if (cmd.scan_step) begin
                scan_reg <= scan_reg + CW'(1);
                if (hit) begin
                    valid_reg[sidx] <= 1'b0;
                end
            end
            if (cmd.place && free_found) begin
                valid_reg[free_idx] <= 1'b1;
            end
        end
    end

    // Slot entry writes.
    always_ff @(posedge aclk) begin
        if (cmd.place && free_found) begin
            sdest_mem[free_idx] <= dest_reg;
            sdue_mem[free_idx]  <= now_reg + delay_reg;
            spay_mem[free_idx]  <= pay_reg;
        end
    end

    // Last flag: no later slot is due.
    logic later_due;
    always_comb begin
        logic [31:0] d;
        later_due = 1'b0;
        for (int i = 0; i < QUEUE_SLOTS; i++) begin
            d = now_reg - sdue_mem[i];
            if (CW'(i) > scan_reg && valid_reg[i] && !d[31]) begin
                later_due = 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.emit_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            if (mode_reg == llde_pkg::MODE_TICK) begin
                m_data.out_dest    <= sdest_mem[sidx];
                m_data.out_payload <= 64'(spay_mem[sidx]);
                m_data.last        <= !later_due;
            end else begin
                m_data.out_dest    <= dest_reg;
                m_data.out_payload <= 64'(pay_reg);
                m_data.last        <= 1'b1;
            end
        end
    end

    // Status.
    always_comb begin
        stat.mode       = mode_reg;
        stat.loss_nz    = (loss_reg != '0);
        stat.jitter_nz  = (jitter_reg != '0);
        stat.mod_done   = !mbusy_reg;
        stat.loss_drop  = (rem_reg < {25'd0, loss_reg});
        stat.delay_zero = (delay_reg == '0);
        stat.scan_done  = (scan_reg >= CW'(QUEUE_SLOTS));
        stat.hit        = hit;
        stat.out_busy   = m_valid && !m_ready;
    end

endmodule

[rtl/core/llde_checker.sv]
// Port checker for the link loss and delay emulator, with its bind.
`timescale 1ns / 1ps
module llde_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input llde_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input llde_pkg::out_item_t m_data
);

    // A waiting result holds still.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // After a transfer in, the block is busy in the next cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after an accepted item");

    // An item taken while no result waits never causes a result in the cycle after it is taken.
    a_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result too early");

    // No result is shown once reset has been sampled.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result after reset");

endmodule

bind link_loss_delay_emulator llde_checker u_llde_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
